// File: rtl/drte_pkg.sv
// Shared types and constants for the DNS response TTL extractor.
// No dependencies.
package drte_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned TTL_W  = 16;
    localparam int unsigned GATH_W = 32;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [TTL_W-1:0] DEFAULT_TTL_RST = 16'd30;
    localparam logic [TTL_W-1:0] MAX_TTL_RST     = 16'd3600;

    localparam logic REG_DEFAULT_TTL = 1'b0;
    localparam logic REG_MAX_TTL     = 1'b1;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_QNAME  = 2'd1;
    localparam logic [1:0] PH_ANSWER = 2'd2;

    localparam logic [7:0] RCODE_MASK = 8'h0F;
    localparam logic [7:0] PTR_MASK   = 8'hC0;

    // Byte positions inside the header
    localparam int unsigned POS_RCODE   = 3;
    localparam int unsigned POS_AN_HI   = 6;
    localparam int unsigned POS_AN_LO   = 7;
    localparam int unsigned POS_HDR_END = 11;
    localparam int unsigned HDR_BYTES   = 12;
    localparam int unsigned MIN_BYTES   = 4;

    // Offsets from the start of the answer record
    localparam int unsigned QTAIL_BYTES = 4;
    localparam int unsigned TTL_FIRST   = 6;
    localparam int unsigned TTL_LAST    = 9;
    localparam int unsigned ANS_MIN     = 10;

    typedef struct packed {
        logic last;
        logic taken;
    } drte_tag_t;

endpackage

// File: rtl/drte_front.sv
// Front end: accepts message bytes, tracks position and size limit,
// and tags each transfer for the back end. Uses drte_pkg.
module drte_front
    import drte_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 2048,
    parameter int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              q_full,
    input  logic              last_byte,
    output logic              push,
    output logic [CNT_W-1:0]  pos,
    output drte_tag_t         tag
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             taken;

    assign taken = count_reg < CNT_W'(MAX_MESSAGE_BYTES);
    assign push  = in_valid && !q_full;
    assign pos   = count_reg;
    assign tag   = '{last: last_byte, taken: taken};

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            if (last_byte)
                count_next = '0;
            else if (taken)
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// File: rtl/drte_queue.sv
// Two-entry queue between the front and back ends.
// Uses drte_pkg.
module drte_queue
    import drte_pkg::*;
#(
    parameter int unsigned WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             do_wr;
    logic             do_rd;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign do_wr     = push && !full;
    assign do_rd     = pop && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: rtl/drte_back.sv
// Back end: walks header, question name and first answer record,
// builds the result on the last byte. Uses drte_pkg.
module drte_back
    import drte_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 2048,
    parameter int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1),
    parameter int unsigned W = $clog2(MAX_MESSAGE_BYTES + 256)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [CNT_W-1:0]  item_pos,
    input  logic [DATA_W-1:0] item_byte,
    input  drte_tag_t         item_tag,
    output logic              pop,
    input  logic [TTL_W-1:0]  default_ttl,
    input  logic [TTL_W-1:0]  max_ttl,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              success,
    output logic [TTL_W-1:0]  ttl_seconds,
    output logic              ttl_from_record
);

    logic [1:0]        phase_reg, phase_next;
    logic [W-1:0]      label_reg, label_next;
    logic [W-1:0]      ans_reg, ans_next;
    logic [GATH_W-1:0] gath_reg, gath_next;
    logic              rcz_reg, rcz_next;
    logic              anp_reg, anp_next;
    logic              nptr_reg, nptr_next;

    logic              out_valid_reg, out_valid_next;
    logic              success_reg, success_next;
    logic [TTL_W-1:0]  ttl_reg, ttl_next;
    logic              from_rec_reg, from_rec_next;

    logic              fire;
    logic [W-1:0]      p;
    logic [W-1:0]      len;
    logic              usable;

    // A result-bearing transfer needs the output register to be free
    assign pop  = !item_tag.last || !out_valid_reg || !out_stall;
    assign fire = item_valid && pop;
    assign p    = W'(item_pos);
    assign len  = item_tag.taken ? p + W'(1) : p;

    always_comb
    begin
        phase_next = phase_reg;
        label_next = label_reg;
        ans_next   = ans_reg;
        gath_next  = gath_reg;
        rcz_next   = rcz_reg;
        anp_next   = anp_reg;
        nptr_next  = nptr_reg;
        if (fire && item_tag.taken)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (p == W'(POS_RCODE))
                        rcz_next = (item_byte & RCODE_MASK) == '0;
                    else if (p == W'(POS_AN_HI))
                        anp_next = item_byte != '0;
                    else if (p == W'(POS_AN_LO))
                        anp_next = anp_reg || (item_byte != '0);
                    if (p == W'(POS_HDR_END))
                        phase_next = PH_QNAME;
                end
                PH_QNAME:
                begin
                    if (p == label_reg)
                    begin
                        if (item_byte == '0)
                        begin
                            ans_next   = p + W'(1 + QTAIL_BYTES);
                            phase_next = PH_ANSWER;
                        end
                        else if ((item_byte & PTR_MASK) != '0)
                        begin
                            ans_next   = p + W'(2 + QTAIL_BYTES);
                            phase_next = PH_ANSWER;
                        end
                        else
                            label_next = p + W'(item_byte) + W'(1);
                    end
                end
                PH_ANSWER:
                begin
                    if (p == ans_reg)
                        nptr_next = (item_byte & PTR_MASK) != '0;
                    else if (p >= ans_reg + W'(TTL_FIRST) && p <= ans_reg + W'(TTL_LAST))
                        gath_next = {gath_reg[GATH_W-DATA_W-1:0], item_byte};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign usable = len >= W'(HDR_BYTES) && anp_next && phase_next == PH_ANSWER
                    && ans_next + W'(ANS_MIN) <= len && nptr_next
                    && gath_next != '0 && gath_next[GATH_W-1:TTL_W] == '0
                    && gath_next[TTL_W-1:0] <= max_ttl;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        success_next   = success_reg;
        ttl_next       = ttl_reg;
        from_rec_next  = from_rec_reg;
        if (fire && item_tag.last)
        begin
            out_valid_next = 1'b1;
            success_next   = len >= W'(MIN_BYTES) && rcz_next;
            ttl_next       = usable ? gath_next[TTL_W-1:0] : default_ttl;
            from_rec_next  = usable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            label_reg     <= W'(HDR_BYTES);
            ans_reg       <= '0;
            gath_reg      <= '0;
            rcz_reg       <= 1'b0;
            anp_reg       <= 1'b0;
            nptr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire && item_tag.last)
            begin
                // message done: clear for the next one
                phase_reg <= PH_HEADER;
                label_reg <= W'(HDR_BYTES);
                ans_reg   <= '0;
                gath_reg  <= '0;
                rcz_reg   <= 1'b0;
                anp_reg   <= 1'b0;
                nptr_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                label_reg <= label_next;
                ans_reg   <= ans_next;
                gath_reg  <= gath_next;
                rcz_reg   <= rcz_next;
                anp_reg   <= anp_next;
                nptr_reg  <= nptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        success_reg  <= success_next;
        ttl_reg      <= ttl_next;
        from_rec_reg <= from_rec_next;
    end

    assign out_valid       = out_valid_reg;
    assign success         = success_reg;
    assign ttl_seconds     = ttl_reg;
    assign ttl_from_record = from_rec_reg;

endmodule

// File: rtl/dns_response_ttl_extractor.sv
// DNS response TTL extractor, top level. Uses drte_pkg, drte_front,
// drte_queue and drte_back.
// Throughput: one byte per cycle while in_stall is low; the front end counts positions,
// the back end updates the parse state once per byte. A last byte waits in the queue
// while an earlier result is held by out_stall. The last byte is written to a queue
// entry, which feeds the output register that drives out_valid.
// Reset: message state cleared, default_ttl = 30, max_ttl = 3600.
module dns_response_ttl_extractor
    import drte_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              success,
    output logic [TTL_W-1:0]  ttl_seconds,
    output logic              ttl_from_record,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int unsigned Q_W   = CNT_W + DATA_W + $bits(drte_tag_t);

    logic [TTL_W-1:0] default_ttl_reg;
    logic [TTL_W-1:0] max_ttl_reg;
    logic             cfg_wr;

    logic             q_full;
    logic             q_not_empty;
    logic             push;
    logic             pop;
    logic [CNT_W-1:0] f_pos;
    drte_tag_t        f_tag;
    logic [Q_W-1:0]   q_wr_data;
    logic [Q_W-1:0]   q_rd_data;
    logic [CNT_W-1:0] b_pos;
    logic [DATA_W-1:0] b_byte;
    drte_tag_t        b_tag;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX_TTL) ? CFG_W'(max_ttl_reg) : CFG_W'(default_ttl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_ttl_reg <= DEFAULT_TTL_RST;
            max_ttl_reg     <= MAX_TTL_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DEFAULT_TTL)
                default_ttl_reg <= pwdata[TTL_W-1:0];
            else
                max_ttl_reg <= pwdata[TTL_W-1:0];
        end
    end

    assign in_stall = q_full;

    drte_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .q_full    (q_full),
        .last_byte (last_byte),
        .push      (push),
        .pos       (f_pos),
        .tag       (f_tag)
    );

    assign q_wr_data = {f_pos, data_byte, f_tag};

    drte_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (q_wr_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    assign {b_pos, b_byte, b_tag} = q_rd_data;

    drte_back #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (q_not_empty),
        .item_pos        (b_pos),
        .item_byte       (b_byte),
        .item_tag        (b_tag),
        .pop             (pop),
        .default_ttl     (default_ttl_reg),
        .max_ttl         (max_ttl_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .success         (success),
        .ttl_seconds     (ttl_seconds),
        .ttl_from_record (ttl_from_record)
    );

endmodule
